@@ design/rrs_pkg.sv @@
// Package for the rounded-rect staircase block: widths, defaults, shared types.
// No dependencies.
package rrs_pkg;

  localparam int unsigned PixelsPerStep = 6;
  localparam int unsigned MaxSteps      = 8;

  // Classified job handed from front to back.
  typedef struct packed {
    logic signed [14:0] left;
    logic signed [14:0] top;
    logic [13:0]        w;
    logic [13:0]        h;
    logic [13:0]        r;     // clamped radius
    logic               empty; // nothing but the empty marker
    logic               plain; // whole rectangle
  } job_t;

endpackage

@@ design/rrs_front.sv @@
// Front part: accepts a rectangle, clamps the radius and classifies the word.
// Depends on rrs_pkg.
module rrs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] left_i,
  input  logic signed [14:0] top_i,
  input  logic [13:0]        rect_width_i,
  input  logic [13:0]        rect_height_i,
  input  logic [13:0]        radius_i,
  output logic               job_valid_o,
  input  logic               job_take_i,
  output rrs_pkg::job_t      job_o
);

  // Two-entry queue between the front and the back.
  rrs_pkg::job_t q_mem [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  rrs_pkg::job_t job_in;
  logic [12:0]   shorter;
  logic          push, pop;

  always_comb begin
    shorter       = (rect_width_i < rect_height_i) ? rect_width_i[13:1] : rect_height_i[13:1];
    job_in.left   = left_i;
    job_in.top    = top_i;
    job_in.w      = rect_width_i;
    job_in.h      = rect_height_i;
    job_in.r      = (radius_i < {1'b0, shorter}) ? radius_i : {1'b0, shorter};
    job_in.empty  = (rect_width_i == '0) || (rect_height_i == '0);
    job_in.plain  = (job_in.r == '0);
  end

  assign in_stall    = (cnt_q == 2'd2);
  assign push        = in_valid && !in_stall;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_take_i;
  assign job_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= job_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ design/rrs_isqrt.sv @@
// Iterative integer square root, one result bit per cycle (28-bit radicand).
// No dependencies.
module rrs_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [27:0] val_i,
  output logic        done_o,
  output logic [13:0] root_o
);

  logic [27:0] rem_q;
  logic [13:0] root_q;
  logic [3:0]  idx_q;
  logic        busy_q;
  logic [27:0] trial;
  logic [27:0] bitv;

  always_comb begin
    bitv  = 28'd1 << {idx_q, 1'b0};
    trial = ({14'd0, root_q} << (idx_q + 4'd1)) + bitv;
  end

  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      idx_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= 4'd13;
        rem_q  <= val_i;
        root_q <= '0;
      end else if (busy_q) begin
        // test next bit of the root
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= root_q | (14'd1 << idx_q);
        end
        if (idx_q == 4'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          idx_q <= idx_q - 4'd1;
        end
      end
    end
  end

endmodule

@@ design/rrs_back.sv @@
// Back part: walks the steps of one job and emits rectangles through an output register.
// Depends on rrs_pkg and rrs_isqrt.
module rrs_back #(
  parameter int unsigned PIXELS_PER_STEP = rrs_pkg::PixelsPerStep,
  parameter int unsigned MAX_STEPS       = rrs_pkg::MaxSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_take_o,
  input  rrs_pkg::job_t      job_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic [13:0]        out_width_o,
  output logic [13:0]        out_height_o,
  output logic               is_empty_o,
  output logic               last_o
);

  localparam int unsigned SW = $clog2(MAX_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MID, S_STEP, S_DIVN, S_DIVF, S_SQRT, S_SWAIT,
    S_TOP, S_BOT, S_FINAL
  } state_e;

  state_e        state_q;
  rrs_pkg::job_t job_q;
  logic [SW-1:0] steps_q, i_q;
  logic [SW-1:0] steps_calc;
  logic          any_q;
  // shared restoring divider
  logic [18:0]   num_q, quo_q;
  logic [18:0]   rem_q;
  logic [4:0]    dcnt_q;
  logic [13:0]   near_q, far_q, inset_q;
  logic          sq_start;
  logic [27:0]   sq_val;
  logic          sq_done;
  logic [13:0]   sq_root;
  logic [19:0]   rem_sh;
  logic [13:0]   divisor;
  logic signed [15:0] bw;
  logic [13:0]   dd;
  logic          load_ok, mid_ok, band_ok, emit;

  // buffered last rectangle: emit after we know whether more follow
  logic          pend_q;
  logic signed [15:0] px_q, py_q;
  logic [13:0]   pw_q, ph_q;

  // step count: largest k in 3..MAX_STEPS with r >= k * PIXELS_PER_STEP, else 2
  always_comb begin
    steps_calc = SW'(2);
    for (int k = 3; k <= MAX_STEPS; k++) begin
      if (32'(job_q.r) >= k * PIXELS_PER_STEP) steps_calc = SW'(k);
    end
  end

  assign divisor = {{(14-SW){1'b0}}, steps_q};
  assign rem_sh  = {rem_q, num_q[18]};
  assign dd      = job_q.r - near_q;
  assign sq_val  = 28'(job_q.r * job_q.r) - 28'(dd * dd);
  assign bw      = $signed({2'b0, job_q.w}) - $signed({1'b0, inset_q, 1'b0});
  assign sq_start = (state_q == S_SQRT);
  assign job_take_o = (state_q == S_IDLE) && job_valid_i;

  // output register free at this edge, and whether a word is loaded into it
  assign load_ok = !out_valid || !out_stall;
  assign mid_ok  = {1'b0, job_q.h} > {job_q.r, 1'b0};
  assign band_ok = (bw > 0) && (far_q != near_q);
  assign emit    = load_ok && (((state_q == S_MID) && pend_q && mid_ok) ||
                               ((state_q == S_TOP) && pend_q && band_ok) ||
                               (state_q == S_BOT) || (state_q == S_FINAL));

  rrs_isqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_val), .done_o(sq_done), .root_o(sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_valid <= 1'b0;
      pend_q    <= 1'b0;
      any_q     <= 1'b0;
      job_q     <= '0;
      steps_q   <= '0; i_q <= '0;
      num_q <= '0; quo_q <= '0; rem_q <= '0; dcnt_q <= '0;
      near_q <= '0; far_q <= '0; inset_q <= '0;
      px_q <= '0; py_q <= '0; pw_q <= '0; ph_q <= '0;
      out_x_o <= '0; out_y_o <= '0; out_width_o <= '0; out_height_o <= '0;
      is_empty_o <= 1'b0; last_o <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
      unique case (state_q)
        S_IDLE: if (job_valid_i) begin
          job_q <= job_i;
          any_q <= 1'b0;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (job_q.empty) state_q <= S_FINAL;
          else if (job_q.plain) begin
            pend_q <= 1'b1; any_q <= 1'b1;
            px_q <= 16'(job_q.left); py_q <= 16'(job_q.top);
            pw_q <= job_q.w; ph_q <= job_q.h;
            state_q <= S_FINAL;
          end else begin
            steps_q <= steps_calc;
            i_q <= '0;
            state_q <= S_MID;
          end
        end
        S_DIVN, S_DIVF: begin
          // one quotient bit per cycle
          if (dcnt_q != '0) begin
            num_q <= num_q << 1;
            if (rem_sh >= {6'd0, divisor}) begin
              rem_q <= 19'(rem_sh - {6'd0, divisor});
              quo_q <= {quo_q[17:0], 1'b1};
            end else begin
              rem_q <= rem_sh[18:0];
              quo_q <= {quo_q[17:0], 1'b0};
            end
            dcnt_q <= dcnt_q - 5'd1;
          end else if (state_q == S_DIVN) begin
            near_q <= 14'(quo_q);
            num_q <= 19'((32'(i_q) + 32'd1) * 32'(job_q.r));
            rem_q <= '0; quo_q <= '0; dcnt_q <= 5'd19;
            state_q <= S_DIVF;
          end else begin
            far_q <= 14'(quo_q);
            state_q <= S_SQRT;
          end
        end
        S_MID: if (!pend_q || !out_valid || !out_stall) begin
          if (mid_ok) begin
            if (pend_q) begin
              out_x_o <= px_q; out_y_o <= py_q;
              out_width_o <= pw_q; out_height_o <= ph_q;
              is_empty_o <= 1'b0; last_o <= 1'b0;
            end
            pend_q <= 1'b1; any_q <= 1'b1;
            px_q <= 16'(job_q.left);
            py_q <= 16'(job_q.top) + 16'(job_q.r);
            pw_q <= job_q.w;
            ph_q <= job_q.h - {job_q.r[12:0], 1'b0};
          end
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (i_q == steps_q) state_q <= S_FINAL;
          else begin
            num_q <= 19'(32'(i_q) * 32'(job_q.r));
            rem_q <= '0; quo_q <= '0; dcnt_q <= 5'd19;
            state_q <= S_DIVN;
          end
        end
        S_SQRT: state_q <= S_SWAIT;
        S_SWAIT: if (sq_done) begin
          inset_q <= job_q.r - sq_root;
          state_q <= S_TOP;
        end
        S_TOP: if (!pend_q || !out_valid || !out_stall) begin
          if (band_ok) begin
            if (pend_q) begin
              out_x_o <= px_q; out_y_o <= py_q;
              out_width_o <= pw_q; out_height_o <= ph_q;
              is_empty_o <= 1'b0; last_o <= 1'b0;
            end
            pend_q <= 1'b1; any_q <= 1'b1;
            px_q <= 16'(job_q.left) + 16'(inset_q);
            py_q <= 16'(job_q.top) + 16'(near_q);
            pw_q <= bw[13:0]; ph_q <= far_q - near_q;
            state_q <= S_BOT;
          end else begin
            i_q <= i_q + SW'(1);
            state_q <= S_STEP;
          end
        end
        S_BOT: if (!out_valid || !out_stall) begin
          out_x_o <= px_q; out_y_o <= py_q;
          out_width_o <= pw_q; out_height_o <= ph_q;
          is_empty_o <= 1'b0; last_o <= 1'b0;
          py_q <= 16'(job_q.top) + 16'(job_q.h) - 16'(far_q);
          i_q <= i_q + SW'(1);
          state_q <= S_STEP;
        end
        S_FINAL: if (!out_valid || !out_stall) begin
          last_o <= 1'b1;
          if (any_q) begin
            out_x_o <= px_q; out_y_o <= py_q;
            out_width_o <= pw_q; out_height_o <= ph_q; is_empty_o <= 1'b0;
          end else begin
            out_x_o <= '0; out_y_o <= '0;
            out_width_o <= '0; out_height_o <= '0; is_empty_o <= 1'b1;
          end
          pend_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/rounded_rect_staircase.sv @@
// Top level of the rounded-rect staircase: front queue plus step engine.
// Depends on rrs_pkg, rrs_front, rrs_back.
//
//   channel  handshake            payload
//   in       in_valid/in_stall    left_i top_i rect_width_i rect_height_i radius_i
//   out      out_valid/out_stall  out_x_o out_y_o out_width_o out_height_o is_empty_o last_o
//
// Each item passes the control states and then, per step, two divisions on the
// shared divider, a square root wait and the sequencing states, plus any output
// stalls. The front queues two items while the back works.
// Reset is asynchronous and clears all control state.
// A stalled output holds the engine.
module rounded_rect_staircase #(
  parameter int unsigned PIXELS_PER_STEP = rrs_pkg::PixelsPerStep,
  parameter int unsigned MAX_STEPS       = rrs_pkg::MaxSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] left_i,
  input  logic signed [14:0] top_i,
  input  logic [13:0]        rect_width_i,
  input  logic [13:0]        rect_height_i,
  input  logic [13:0]        radius_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic [13:0]        out_width_o,
  output logic [13:0]        out_height_o,
  output logic               is_empty_o,
  output logic               last_o
);

  rrs_pkg::job_t job;
  logic          job_valid, job_take;

  rrs_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .left_i, .top_i, .rect_width_i,
    .rect_height_i, .radius_i, .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  rrs_back #(.PIXELS_PER_STEP(PIXELS_PER_STEP), .MAX_STEPS(MAX_STEPS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .out_valid, .out_stall, .out_x_o, .out_y_o, .out_width_o, .out_height_o,
    .is_empty_o, .last_o
  );

endmodule

@@ design/rrs_checker.sv @@
// Port checker for the rounded-rect staircase, bound to the top level.
// Depends on rounded_rect_staircase ports only.
module rrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_stall,
  input logic [13:0] out_width_o,
  input logic [13:0] out_height_o,
  input logic        is_empty_o,
  input logic        last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_width_o))
    else $error("stalled word changed");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_empty_o |-> last_o && out_width_o == '0 && out_height_o == '0)
    else $error("empty word malformed");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !is_empty_o |-> out_width_o != '0 && out_height_o != '0)
    else $error("zero-sized rectangle");

endmodule

bind rounded_rect_staircase rrs_checker u_chk (
  .clk_i, .rst_ni, .out_valid, .out_stall, .out_width_o, .out_height_o, .is_empty_o, .last_o
);

@@ tb/tb_rounded_rect_staircase.sv @@
// Testbench for rounded_rect_staircase: random and directed rectangles, with a
// self-contained staircase predictor and an in-order scoreboard of result words.
// Depends on rrs_pkg and the rounded_rect_staircase RTL.
`timescale 1ns / 1ps

module tb_rounded_rect_staircase;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [13:0]        w;
    logic [13:0]        h;
    logic               empty;
    logic               last;
  } rect_word_t;

  class staircase_board;
    rect_word_t pending[$];
    int unsigned errors;

    function automatic int unsigned floor_sqrt(int unsigned v);
      int unsigned root;
      root = 0;
      while ((root + 1) * (root + 1) <= v) root++;
      return root;
    endfunction

    function automatic void push_rect(int x, int y, int w, int h, bit empty);
      rect_word_t word;
      word.x = x[15:0];
      word.y = y[15:0];
      word.w = w[13:0];
      word.h = h[13:0];
      word.empty = empty;
      word.last = 1'b0;
      pending.push_back(word);
    endfunction

    // Expand one accepted rectangle into its staircase words.
    function automatic void note_rect(logic signed [14:0] left, logic signed [14:0] top,
                                      logic [13:0] wd, logic [13:0] ht, logic [13:0] rad);
      int lx, ty, w, h, r, shorter, steps, near_row, far_row, inset, bw, bh, first;
      int unsigned d, rr;
      lx = int'(left);
      ty = int'(top);
      w = int'(wd);
      h = int'(ht);
      first = pending.size();
      if (w > 0 && h > 0) begin
        shorter = (w < h ? w : h) / 2;
        r = (rad < shorter) ? int'(rad) : shorter;
        if (r <= 0) begin
          push_rect(lx, ty, w, h, 1'b0);
        end else begin
          steps = r / rrs_pkg::PixelsPerStep;
          if (steps < 2) steps = 2;
          if (steps > rrs_pkg::MaxSteps) steps = rrs_pkg::MaxSteps;
          if (h - 2 * r > 0) push_rect(lx, ty + r, w, h - 2 * r, 1'b0);
          for (int i = 0; i < steps; i++) begin
            near_row = i * r / steps;
            far_row = (i + 1) * r / steps;
            d = r - near_row;
            rr = r * r;
            inset = r - int'(floor_sqrt(rr - d * d));
            bw = w - 2 * inset;
            bh = far_row - near_row;
            if (bw > 0 && bh > 0) begin
              push_rect(lx + inset, ty + near_row, bw, bh, 1'b0);
              push_rect(lx + inset, ty + h - far_row, bw, bh, 1'b0);
            end
          end
        end
      end
      if (pending.size() == first) push_rect(0, 0, 0, 0, 1'b1);
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_word(rect_word_t got);
      rect_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d w=%0d h=%0d", $time,
                 got.x, got.y, got.w, got.h);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected x=%0d y=%0d w=%0d h=%0d e=%0b l=%0b", $time,
                 want.x, want.y, want.w, want.h, want.empty, want.last);
        $display("%0t:          actual   x=%0d y=%0d w=%0d h=%0d e=%0b l=%0b", $time,
                 got.x, got.y, got.w, got.h, got.empty, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [14:0] left_i = '0;
  logic signed [14:0] top_i = '0;
  logic [13:0] rect_width_i = '0;
  logic [13:0] rect_height_i = '0;
  logic [13:0] radius_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_x_o;
  logic signed [15:0] out_y_o;
  logic [13:0] out_width_o;
  logic [13:0] out_height_o;
  logic is_empty_o;
  logic last_o;

  staircase_board board = new();
  bit stall_mode;
  longint unsigned cycle_count = 0;
  localparam longint unsigned CycleLimit = 4_000_000;

  rounded_rect_staircase u_dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // Count cycles and abort on a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("rounded_rect_staircase verification failed");
      $finish;
    end
  end

  // Check accepted words; stall in patterns, sometimes not at all.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      board.check_word({out_x_o, out_y_o, out_width_o, out_height_o, is_empty_o, last_o});
    if (($urandom % 200) == 0) stall_mode = ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b0;
  end

  task automatic send_rect(logic [14:0] l, logic [14:0] t, logic [13:0] w,
                           logic [13:0] h, logic [13:0] r);
    in_valid <= 1'b1;
    left_i <= l;
    top_i <= t;
    rect_width_i <= w;
    rect_height_i <= h;
    radius_i <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    board.note_rect(l, t, w, h, r);
  endtask

  task automatic pause_sender(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Mostly small sizes so the engine stays fast; a few full-range items.
  task automatic send_random();
    logic [13:0] w, h, r;
    case ($urandom_range(0, 9))
      0: begin w = 14'($urandom); h = 14'($urandom); r = 14'($urandom); end
      1: begin
        w = 14'($urandom_range(0, 3));
        h = 14'($urandom_range(0, 3));
        r = 14'($urandom_range(0, 3));
      end
      default: begin
        w = 14'($urandom_range(1, 120));
        h = 14'($urandom_range(1, 120));
        r = 14'($urandom_range(0, 70));
      end
    endcase
    send_rect(15'($urandom), 15'($urandom), w, h, r);
  endtask

  initial begin
    int unsigned burst;
    stall_mode = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty inputs, plain rectangle, clamping, tiny and extreme sizes.
    send_rect(15'sh4000, 15'sh4000, 14'd0, 14'd10, 14'd3);
    send_rect(15'sh3fff, 15'sh3fff, 14'd10, 14'd0, 14'd3);
    send_rect(15'sd0, 15'sd0, 14'd0, 14'd0, 14'd0);
    send_rect(15'sd5, -15'sd5, 14'd20, 14'd30, 14'd0);
    send_rect(15'sd1, 15'sd2, 14'd1, 14'd1, 14'd5);
    send_rect(15'sd1, 15'sd2, 14'd2, 14'd2, 14'd1);
    send_rect(15'sd1, 15'sd2, 14'd3, 14'd3, 14'd1);
    send_rect(-15'sd7, 15'sd9, 14'd40, 14'd40, 14'd20);
    send_rect(-15'sd7, 15'sd9, 14'd40, 14'd60, 14'd100);
    send_rect(15'sd0, 15'sd0, 14'd100, 14'd30, 14'd11);
    send_rect(15'sd0, 15'sd0, 14'd100, 14'd30, 14'd12);
    send_rect(15'sh3fff, 15'sh3fff, 14'h3fff, 14'h3fff, 14'h3fff);
    send_rect(15'sh4000, 15'sh4000, 14'h3fff, 14'h3fff, 14'h3fff);
    send_rect(15'sh2aaa, 15'sh1555, 14'h2aaa, 14'h1555, 14'd48);
    send_rect(15'sh1555, 15'sh2aaa, 14'h1555, 14'h2aaa, 14'h3fff);
    send_rect(15'sd3, 15'sd3, 14'd13, 14'd200, 14'd6);
    pause_sender(1);
    // Drain completely once before random traffic.
    while (board.pending.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 450; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < 450; k++, n++) send_random();
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 40));
      else if (n % 150 < 12) begin
        pause_sender(1);
        while (board.pending.size() != 0) @(posedge clk_i);
      end
    end
    pause_sender(1);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("rounded_rect_staircase verification clean");
    else
      $display("rounded_rect_staircase verification failed");
    $finish;
  end

endmodule
